### hdl/s2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, key codes and the set-1 key translation table for the
// scancode to ASCII router.
// ----------------------------------------------------------------------------

package s2a_pkg;

    // Widths of the transaction fields.
    localparam int unsigned SCAN_W   = 8;
    localparam int unsigned KEY_W    = 7;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COL_W    = 4;
    localparam int unsigned SHIFT_W  = 2;
    localparam int unsigned COL_MAX  = 15;

    // Result actions.
    localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOCAL_CHAR = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOCAL_BS   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FORWARD    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FOCUS      = 3'd4;

    // Special scancodes.
    localparam logic [SCAN_W-1:0] SC_BACKSPACE    = 8'h0e;
    localparam logic [SCAN_W-1:0] SC_TAB          = 8'h0f;
    localparam logic [SCAN_W-1:0] SC_ENTER        = 8'h1c;
    localparam logic [SCAN_W-1:0] SC_CAPS         = 8'h3a;
    localparam logic [SCAN_W-1:0] SC_LSHIFT       = 8'h2a;
    localparam logic [SCAN_W-1:0] SC_RSHIFT       = 8'h36;
    localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hb6;

    // Character constants and console commands.
    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_TO_CONSOLE  = 8'h02;
    localparam logic [CHAR_W-1:0] CMD_TO_LOCAL    = 8'h03;

    // Both table entries for one key, read together.
    typedef struct packed {
        logic [CHAR_W-1:0] plain;
        logic [CHAR_W-1:0] shifted;
    } key_entry_t;

    // Set-1 make code translation. Letters come back in upper case.
    function automatic logic [CHAR_W-1:0] key_char(input logic sh, input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        ch = 8'h00;
        case (key)
            7'h02: ch = sh ? 8'h21 : 8'h31;
            7'h03: ch = sh ? 8'h40 : 8'h32;
            7'h04: ch = sh ? 8'h23 : 8'h33;
            7'h05: ch = sh ? 8'h24 : 8'h34;
            7'h06: ch = sh ? 8'h25 : 8'h35;
            7'h07: ch = sh ? 8'h5e : 8'h36;
            7'h08: ch = sh ? 8'h26 : 8'h37;
            7'h09: ch = sh ? 8'h2a : 8'h38;
            7'h0a: ch = sh ? 8'h28 : 8'h39;
            7'h0b: ch = sh ? 8'h29 : 8'h30;
            7'h0c: ch = sh ? 8'h5f : 8'h2d;
            7'h0d: ch = sh ? 8'h2b : 8'h3d;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4f;
            7'h19: ch = 8'h50;
            7'h1a: ch = sh ? 8'h7b : 8'h5b;
            7'h1b: ch = sh ? 8'h7d : 8'h5d;
            7'h1e: ch = 8'h41;
            7'h1f: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4a;
            7'h25: ch = 8'h4b;
            7'h26: ch = 8'h4c;
            7'h27: ch = sh ? 8'h3a : 8'h3b;
            7'h28: ch = sh ? 8'h22 : 8'h27;
            7'h29: ch = sh ? 8'h7e : 8'h60;
            7'h2b: ch = sh ? 8'h7c : 8'h5c;
            7'h2c: ch = 8'h5a;
            7'h2d: ch = 8'h58;
            7'h2e: ch = 8'h43;
            7'h2f: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4e;
            7'h32: ch = 8'h4d;
            7'h33: ch = sh ? 8'h3c : 8'h2c;
            7'h34: ch = sh ? 8'h3e : 8'h2e;
            7'h35: ch = sh ? 8'h3f : 8'h2f;
            7'h37: ch = 8'h2a;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4a: ch = 8'h2d;
            7'h4b: ch = 8'h34;
            7'h4c: ch = 8'h35;
            7'h4d: ch = 8'h36;
            7'h4e: ch = 8'h2b;
            7'h4f: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2e;
            7'h73: ch = sh ? 8'h5f : 8'h5c;
            7'h7d: ch = sh ? 8'h7c : 8'h5c;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hdl/s2a_keymap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_keymap
// Synchronous key table: one read per cycle, both the plain and the shifted
// entry of the addressed key registered together.
// ----------------------------------------------------------------------------

module s2a_keymap (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [s2a_pkg::KEY_W-1:0]   rd_addr,
    output s2a_pkg::key_entry_t         rd_data
);

    s2a_pkg::key_entry_t entry_reg;

    // Registered read; the entry holds while no read is enabled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            entry_reg.plain   <= s2a_pkg::key_char(1'b0, rd_addr);
            entry_reg.shifted <= s2a_pkg::key_char(1'b1, rd_addr);
        end
    end

    assign rd_data = entry_reg;

endmodule

### hdl/scancode_to_ascii_router_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_router_core
// Set-1 keyboard scancode decoder with shift/caps tracking, a local text
// column and focus routing between a local box and the console.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Payload
// ---------+-----------+---------------------------------------------------
// s_       | in        | scancode (8 bits)
// m_       | out       | action, char_code, column, focus_console,
//          |           | caps_active, shift_held (19 bits in 24)
//
// One transaction per cycle sustained while m_ accepts; each passes the key
// table read stage, then the decode stage that updates the flags and column and
// loads the output register. The state registers change only in the decode
// stage, in transaction order. A stall on m_ holds the output register and
// the table stage; s_tready drops only when both are full. Reset (aresetn,
// synchronous, active low) clears the flags, the column and both valids,
// and holds s_tready low.

module scancode_to_ascii_router_core #(
    parameter int unsigned TEXT_COLUMNS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [2:0] action, [10:3] char_code, [14:11] column,
                                    // [15] focus_console, [16] caps_active,
                                    // [18:17] shift_held, [23:19] zero
);

    localparam int unsigned COL_LIMIT_I =
        (TEXT_COLUMNS > s2a_pkg::COL_MAX) ? s2a_pkg::COL_MAX : TEXT_COLUMNS;
    localparam logic [s2a_pkg::COL_W-1:0] COL_LIMIT = COL_LIMIT_I[s2a_pkg::COL_W-1:0];

    // Table stage.
    logic                           tbl_valid_reg, tbl_valid_next;
    logic [s2a_pkg::SCAN_W-1:0]     tbl_code_reg;
    s2a_pkg::key_entry_t            tbl_entry;
    logic                           s_accept;
    logic                           advance;
    logic                           out_free;

    // State.
    logic [s2a_pkg::SHIFT_W-1:0]    shift_reg, shift_next;
    logic                           caps_reg, caps_next;
    logic                           focus_reg, focus_next;
    logic [s2a_pkg::COL_W-1:0]      col_reg, col_next;

    // Decode results.
    logic [s2a_pkg::CHAR_W-1:0]     raw_char;
    logic [s2a_pkg::CHAR_W-1:0]     dec_char;
    logic                           shifted;
    logic [s2a_pkg::ACTION_W-1:0]   act_next;
    logic [s2a_pkg::CHAR_W-1:0]     emit_next;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    logic [s2a_pkg::ACTION_W-1:0]   m_action_reg;
    logic [s2a_pkg::CHAR_W-1:0]     m_char_reg;
    logic [s2a_pkg::COL_W-1:0]      m_col_reg;
    logic                           m_focus_reg;
    logic                           m_caps_reg;
    logic [s2a_pkg::SHIFT_W-1:0]    m_shift_reg;

    // Handshake and pipeline advance.
    assign out_free       = !m_valid_reg || m_tready;
    assign advance        = tbl_valid_reg && out_free;
    assign s_tready       = aresetn && (!tbl_valid_reg || advance);
    assign s_accept       = s_tvalid && s_tready;
    assign tbl_valid_next = s_accept || (tbl_valid_reg && !advance);
    assign m_valid_next   = advance || (m_valid_reg && !m_tready);

    // Key table lookup, started when the transaction is accepted.
    s2a_keymap u_keymap (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (s_tdata[s2a_pkg::KEY_W-1:0]),
        .rd_data (tbl_entry)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tbl_code_reg <= s_tdata;
        end
    end

    // Character selection with the shift and caps state from before the item.
    always_comb begin
        shifted  = (shift_reg != '0);
        raw_char = tbl_code_reg[s2a_pkg::SCAN_W-1] ? s2a_pkg::CHAR_NUL :
                   (shifted ? tbl_entry.shifted : tbl_entry.plain);
        dec_char = raw_char;
        if (raw_char >= s2a_pkg::CHAR_UPPER_A && raw_char <= s2a_pkg::CHAR_UPPER_Z
            && caps_reg == shifted) begin
            dec_char = raw_char + s2a_pkg::CASE_OFFSET;
        end
    end

    // Action decode and state update.
    always_comb begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        focus_next = focus_reg;
        col_next   = col_reg;
        act_next   = s2a_pkg::ACT_NONE;
        emit_next  = s2a_pkg::CHAR_NUL;
        if (dec_char != s2a_pkg::CHAR_NUL) begin
            if (!focus_reg) begin
                if (col_reg < COL_LIMIT) begin
                    col_next  = col_reg + 1'b1;
                    act_next  = s2a_pkg::ACT_LOCAL_CHAR;
                    emit_next = dec_char;
                end
            end else begin
                act_next  = s2a_pkg::ACT_FORWARD;
                emit_next = dec_char;
            end
        end else begin
            case (tbl_code_reg)
                s2a_pkg::SC_BACKSPACE: begin
                    if (!focus_reg) begin
                        if (col_reg != '0) begin
                            col_next  = col_reg - 1'b1;
                            act_next  = s2a_pkg::ACT_LOCAL_BS;
                            emit_next = s2a_pkg::CHAR_BS;
                        end
                    end else begin
                        act_next  = s2a_pkg::ACT_FORWARD;
                        emit_next = s2a_pkg::CHAR_BS;
                    end
                end
                s2a_pkg::SC_TAB: begin
                    focus_next = !focus_reg;
                    act_next   = s2a_pkg::ACT_FOCUS;
                    emit_next  = focus_reg ? s2a_pkg::CMD_TO_LOCAL : s2a_pkg::CMD_TO_CONSOLE;
                end
                s2a_pkg::SC_ENTER: begin
                    if (focus_reg) begin
                        act_next  = s2a_pkg::ACT_FORWARD;
                        emit_next = s2a_pkg::CHAR_LF;
                    end
                end
                s2a_pkg::SC_CAPS:         caps_next  = !caps_reg;
                s2a_pkg::SC_LSHIFT:       shift_next = shift_reg | 2'b01;
                s2a_pkg::SC_RSHIFT:       shift_next = shift_reg | 2'b10;
                s2a_pkg::SC_LSHIFT_BREAK: shift_next = shift_reg & 2'b10;
                s2a_pkg::SC_RSHIFT_BREAK: shift_next = shift_reg & 2'b01;
                default: begin
                    act_next = s2a_pkg::ACT_NONE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            shift_reg     <= '0;
            caps_reg      <= 1'b0;
            focus_reg     <= 1'b0;
            col_reg       <= '0;
        end else begin
            tbl_valid_reg <= tbl_valid_next;
            m_valid_reg   <= m_valid_next;
            if (advance) begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
                focus_reg <= focus_next;
                col_reg   <= col_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_action_reg <= act_next;
            m_char_reg   <= emit_next;
            m_col_reg    <= col_next;
            m_focus_reg  <= focus_next;
            m_caps_reg   <= caps_next;
            m_shift_reg  <= shift_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_shift_reg, m_caps_reg, m_focus_reg, m_col_reg,
                       m_char_reg, m_action_reg};

`ifndef SYNTHESIS
    // The column never passes the limit.
    a_col_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_LIMIT)
        else $error("text column beyond limit");

    // A local character is only produced with local focus and moves the column.
    a_local_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == s2a_pkg::ACT_LOCAL_CHAR)
            |-> (!m_focus_reg && m_col_reg != '0))
        else $error("local character with console focus or column zero");

    // A focus change reports the command that matches the new focus.
    a_focus_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == s2a_pkg::ACT_FOCUS)
            |-> (m_char_reg == (m_focus_reg ? s2a_pkg::CMD_TO_CONSOLE
                                            : s2a_pkg::CMD_TO_LOCAL)))
        else $error("focus command does not match focus");

    // A transaction leaving the table stage always lands in the output register.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("transaction lost between stages");
`endif

endmodule

### tb/sv/scancode_to_ascii_router_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_router_core_test
// Self-checking testbench for the set-1 scancode to ASCII router core. A
// queue-fed driver sends scancodes in random bursts. A monitor predicts each
// result from its own copy of the key tables, shift/caps/focus flags and text
// column. It compares every result transaction field by field while the
// receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------

module scancode_to_ascii_router_core_test;

    localparam int TB_TEXT_COLUMNS = 15;
    localparam int COL_LIMIT       = (TB_TEXT_COLUMNS > 15) ? 15 : TB_TEXT_COLUMNS;
    localparam int RANDOM_ITEMS    = 950;
    localparam int IDLE_LIMIT      = 2000;

    // One result transaction, packed as on m_tdata[18:0].
    typedef struct packed {
        logic [s2a_pkg::SHIFT_W-1:0]  shift_held;
        logic                         caps_active;
        logic                         focus_console;
        logic [s2a_pkg::COL_W-1:0]    column;
        logic [s2a_pkg::CHAR_W-1:0]   char_code;
        logic [s2a_pkg::ACTION_W-1:0] action;
    } key_result_t;

    // Stimulus mixes and receiver stall patterns.
    typedef enum int {MIX_TYPING, MIX_ERASING, MIX_BALANCED} key_mix_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_pattern_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Unshifted key table, eight codes per line.
    logic [7:0] plain_tab [0:127] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h5b, 8'h5d, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
    };

    // Shifted key table; letters stay upper case here too.
    logic [7:0] shift_tab [0:127] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
    };

    // Opening scancodes: empty-box backspace and enter, the byte extremes,
    // releases, every shift/caps combination, then a console round trip.
    logic [7:0] opening_keys [26] = '{
        s2a_pkg::SC_BACKSPACE, s2a_pkg::SC_ENTER, 8'h00, 8'hff, 8'h7f, 8'h9e,
        8'h1e, s2a_pkg::SC_LSHIFT, 8'h1e, 8'h02, s2a_pkg::SC_LSHIFT_BREAK,
        s2a_pkg::SC_CAPS,
        8'h1e, s2a_pkg::SC_RSHIFT, 8'h1e, s2a_pkg::SC_LSHIFT,
        s2a_pkg::SC_RSHIFT_BREAK, s2a_pkg::SC_LSHIFT_BREAK,
        s2a_pkg::SC_CAPS, s2a_pkg::SC_BACKSPACE, s2a_pkg::SC_TAB, 8'h10,
        s2a_pkg::SC_BACKSPACE, s2a_pkg::SC_ENTER,
        8'h73, s2a_pkg::SC_TAB
    };

    // Predicted keyboard state.
    logic [s2a_pkg::SHIFT_W-1:0] kb_shift = '0;
    logic                        kb_caps  = 1'b0;
    logic                        kb_focus = 1'b0;
    logic [s2a_pkg::COL_W-1:0]   kb_col   = '0;

    logic [7:0]  scan_pending [$];
    key_result_t expected_keys [$];
    key_result_t got_key;
    key_result_t want_key;

    int errors       = 0;
    int keys_sent    = 0;
    int local_chars  = 0;
    int local_erases = 0;
    int forwards     = 0;
    int focus_moves  = 0;
    int full_drops   = 0;
    int idle_cycles  = 0;

    int          burst_left = 0;
    int          gap_left   = 0;
    rx_pattern_t rx_pattern = RX_OPEN;
    int          rx_left    = 0;
    logic [1:0]  rx_phase   = '0;

    scancode_to_ascii_router_core #(
        .TEXT_COLUMNS(TB_TEXT_COLUMNS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Decode one scancode against the predicted state and update that state.
    function automatic key_result_t decode_scancode(input logic [7:0] code);
        key_result_t res;
        logic [7:0]  ch;
        ch = s2a_pkg::CHAR_NUL;
        res.action = s2a_pkg::ACT_NONE;
        res.char_code = s2a_pkg::CHAR_NUL;
        if (!code[7]) begin
            ch = (kb_shift == '0) ? plain_tab[code[6:0]] : shift_tab[code[6:0]];
        end
        // Lower case unless exactly one of caps lock and shift is active.
        if (ch >= s2a_pkg::CHAR_UPPER_A && ch <= s2a_pkg::CHAR_UPPER_Z
            && (kb_caps == (kb_shift != '0))) begin
            ch = ch + s2a_pkg::CASE_OFFSET;
        end
        if (ch != s2a_pkg::CHAR_NUL) begin
            if (!kb_focus) begin
                if (kb_col < COL_LIMIT) begin
                    kb_col = kb_col + 1'b1;
                    res.action = s2a_pkg::ACT_LOCAL_CHAR;
                    res.char_code = ch;
                end else begin
                    full_drops++;
                end
            end else begin
                res.action = s2a_pkg::ACT_FORWARD;
                res.char_code = ch;
            end
        end else if (code == s2a_pkg::SC_BACKSPACE) begin
            if (!kb_focus) begin
                if (kb_col != '0) begin
                    kb_col = kb_col - 1'b1;
                    res.action = s2a_pkg::ACT_LOCAL_BS;
                    res.char_code = s2a_pkg::CHAR_BS;
                end
            end else begin
                res.action = s2a_pkg::ACT_FORWARD;
                res.char_code = s2a_pkg::CHAR_BS;
            end
        end else if (code == s2a_pkg::SC_TAB) begin
            kb_focus = ~kb_focus;
            res.action = s2a_pkg::ACT_FOCUS;
            res.char_code = kb_focus ? s2a_pkg::CMD_TO_CONSOLE : s2a_pkg::CMD_TO_LOCAL;
        end else if (code == s2a_pkg::SC_ENTER) begin
            if (kb_focus) begin
                res.action = s2a_pkg::ACT_FORWARD;
                res.char_code = s2a_pkg::CHAR_LF;
            end
        end else if (code == s2a_pkg::SC_CAPS) begin
            kb_caps = ~kb_caps;
        end else if (code == s2a_pkg::SC_LSHIFT) begin
            kb_shift = kb_shift | 2'b01;
        end else if (code == s2a_pkg::SC_RSHIFT) begin
            kb_shift = kb_shift | 2'b10;
        end else if (code == s2a_pkg::SC_LSHIFT_BREAK) begin
            kb_shift = kb_shift & 2'b10;
        end else if (code == s2a_pkg::SC_RSHIFT_BREAK) begin
            kb_shift = kb_shift & 2'b01;
        end
        res.column = kb_col;
        res.focus_console = kb_focus;
        res.caps_active = kb_caps;
        res.shift_held = kb_shift;
        return res;
    endfunction

    // A make code that maps to a character.
    function automatic logic [7:0] pick_printable();
        logic [6:0] key;
        key = 7'($urandom_range(0, 127));
        while (plain_tab[key] == s2a_pkg::CHAR_NUL) begin
            key = 7'($urandom_range(0, 127));
        end
        return {1'b0, key};
    endfunction

    // One random scancode, weighted by the current stimulus mix.
    function automatic logic [7:0] random_scancode(input key_mix_t mix);
        int roll;
        int shift_pick;
        logic [7:0] code;
        roll = $urandom_range(0, 99);
        shift_pick = $urandom_range(0, 3);
        if (mix == MIX_ERASING) begin
            roll = (roll < 20) ? roll : ((roll < 60) ? 200 : roll);
        end else if (mix == MIX_BALANCED) begin
            roll = (roll < 40) ? roll : ((roll < 52) ? 200 : roll);
        end
        if (roll == 200) begin
            code = s2a_pkg::SC_BACKSPACE;
        end else if (roll < 55) begin
            code = pick_printable();
        end else if (roll < 67) begin
            case (shift_pick)
                0: code = s2a_pkg::SC_LSHIFT;
                1: code = s2a_pkg::SC_RSHIFT;
                2: code = s2a_pkg::SC_LSHIFT_BREAK;
                default: code = s2a_pkg::SC_RSHIFT_BREAK;
            endcase
        end else if (roll < 71) begin
            code = s2a_pkg::SC_CAPS;
        end else if (roll < 76) begin
            code = s2a_pkg::SC_TAB;
        end else if (roll < 81) begin
            code = s2a_pkg::SC_BACKSPACE;
        end else if (roll < 86) begin
            code = s2a_pkg::SC_ENTER;
        end else if (roll < 93) begin
            code = 8'h80 | 8'($urandom_range(0, 127));
        end else begin
            code = 8'($urandom_range(0, 255));
        end
        return code;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Wait until every queued scancode has been sent and answered.
    task automatic wait_drained();
        while (scan_pending.size() != 0 || s_tvalid || expected_keys.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: sends queued scancodes in bursts with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (scan_pending.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= scan_pending.pop_front();
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern changes whenever its random hold count runs out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(30, 200);
            end else begin
                rx_left--;
            end
            case (rx_pattern)
                RX_OPEN:         m_tready <= 1'b1;
                RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
                RX_EVERY_FOURTH: m_tready <= (rx_phase == 2'b00);
                default:         m_tready <= ($urandom_range(0, 7) == 0);
            endcase
            rx_phase = rx_phase + 1'b1;
        end
    end

    // Monitor: predicts on each accepted scancode, checks each result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            kb_shift = '0;
            kb_caps = 1'b0;
            kb_focus = 1'b0;
            kb_col = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_keys.push_back(decode_scancode(s_tdata));
                keys_sent++;
            end
            if (m_tvalid && m_tready) begin
                got_key = key_result_t'(m_tdata[18:0]);
                if (expected_keys.size() == 0) begin
                    $error("result transaction with no scancode pending: %h", m_tdata);
                    errors++;
                end else begin
                    want_key = expected_keys.pop_front();
                    check_field("action", int'(want_key.action), int'(got_key.action));
                    check_field("char_code", int'(want_key.char_code),
                                int'(got_key.char_code));
                    check_field("column", int'(want_key.column), int'(got_key.column));
                    check_field("focus_console", int'(want_key.focus_console),
                                int'(got_key.focus_console));
                    check_field("caps_active", int'(want_key.caps_active),
                                int'(got_key.caps_active));
                    check_field("shift_held", int'(want_key.shift_held),
                                int'(got_key.shift_held));
                    case (want_key.action)
                        s2a_pkg::ACT_LOCAL_CHAR: local_chars++;
                        s2a_pkg::ACT_LOCAL_BS:   local_erases++;
                        s2a_pkg::ACT_FORWARD:    forwards++;
                        s2a_pkg::ACT_FOCUS:      focus_moves++;
                        default:                 ;
                    endcase
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int       queued;
        int       seg_len;
        key_mix_t mix;
        queued = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_keys[i]) begin
            scan_pending.push_back(opening_keys[i]);
        end
        wait_drained();

        // Random segments; halfway through the sender waits for all results.
        while (queued < RANDOM_ITEMS) begin
            mix = key_mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 60);
            for (int i = 0; i < seg_len && queued < RANDOM_ITEMS; i++) begin
                scan_pending.push_back(random_scancode(mix));
                queued++;
                if (queued == RANDOM_ITEMS / 2) begin
                    wait_drained();
                end
            end
        end
        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Sent %0d scancodes: %0d local chars, %0d local backspaces, %0d forwards,",
                 keys_sent, local_chars, local_erases, forwards);
        $display("%0d focus changes and %0d characters dropped on a full text box.",
                 focus_moves, full_drops);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/s2a_pkg.sv
hdl/s2a_keymap.sv
hdl/scancode_to_ascii_router_core.sv
tb/sv/scancode_to_ascii_router_core_test.sv
